>>> sv/lcrs_pkg.sv
// lcrs_pkg: shared widths, reset values, register indexes and the result beat type
// for the line camera readout sequencer; no dependencies

package lcrs_pkg;

    // field and register widths
    localparam int PERIOD_W = 24;
    localparam int IDX_W    = 7;
    localparam int VALUE_W  = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // period reset values
    localparam logic [PERIOD_W-1:0] CLOCK_PERIOD_RST = 24'd250;
    localparam logic [PERIOD_W-1:0] WAIT_PERIOD_RST  = 24'd500000;

    // register index, taken from paddr bit 2
    localparam logic REG_CLOCK_PERIOD = 1'b0;
    localparam logic REG_WAIT_PERIOD  = 1'b1;

    // one result beat
    typedef struct packed {
        logic               si_level;
        logic               clk_level;
        logic               adc_start;
        logic               pixel_valid;
        logic [IDX_W-1:0]   pixel_index;
        logic [VALUE_W-1:0] pixel_value;
        logic               frame_done;
        logic               adc_miss;
    } lcrs_result_t;

endpackage

>>> sv/lcrs_in_if.sv
// lcrs_in_if: valid/ready channel carrying one converter sample beat per tick
// depends on lcrs_pkg

interface lcrs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         adc_done;
    logic [lcrs_pkg::VALUE_W-1:0] adc_value;

    modport source (output valid, output adc_done, output adc_value, input ready);
    modport sink (input valid, input adc_done, input adc_value, output ready);
endinterface

>>> sv/lcrs_out_if.sv
// lcrs_out_if: valid/ready channel carrying one pin and pixel result beat
// depends on lcrs_pkg

interface lcrs_out_if;
    logic                         valid;
    logic                         ready;
    logic                         si_level;
    logic                         clk_level;
    logic                         adc_start;
    logic                         pixel_valid;
    logic [lcrs_pkg::IDX_W-1:0]   pixel_index;
    logic [lcrs_pkg::VALUE_W-1:0] pixel_value;
    logic                         frame_done;
    logic                         adc_miss;

    modport source (
        output valid, output si_level, output clk_level, output adc_start,
        output pixel_valid, output pixel_index, output pixel_value,
        output frame_done, output adc_miss, input ready
    );
    modport sink (
        input valid, input si_level, input clk_level, input adc_start,
        input pixel_valid, input pixel_index, input pixel_value,
        input frame_done, input adc_miss, output ready
    );
endinterface

>>> sv/lcrs_seq.sv
// lcrs_seq: reload timer and seven-phase sensor sequencer, one step per accepted tick
// depends on lcrs_pkg

module lcrs_seq #(
    parameter int PIXEL_COUNT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          adc_done,
    input  logic [lcrs_pkg::VALUE_W-1:0]  adc_value,
    input  logic [lcrs_pkg::PERIOD_W-1:0] clock_period,
    input  logic [lcrs_pkg::PERIOD_W-1:0] wait_period,
    output lcrs_pkg::lcrs_result_t        result
);

    localparam int CNT_W = (PIXEL_COUNT > 2) ? $clog2(PIXEL_COUNT) : 1;
    localparam int EXT_W = (CNT_W > lcrs_pkg::IDX_W) ? CNT_W : lcrs_pkg::IDX_W;
    localparam logic [CNT_W-1:0] LAST_PIXEL = CNT_W'(PIXEL_COUNT - 1);

    typedef enum logic [2:0] {
        PH_INIT,
        PH_SET_SI,
        PH_SI_CLK,
        PH_DROP_BOTH,
        PH_CAPTURE,
        PH_DROP_CLK,
        PH_FRAME_END
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [CNT_W-1:0]              pixel_count_reg, pixel_count_next;
    logic [lcrs_pkg::PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic                          use_wait_reg, use_wait_next;
    logic                          si_reg, si_next;
    logic                          clk_pin_reg, clk_pin_next;
    logic [lcrs_pkg::PERIOD_W-1:0] period_sel;
    logic [EXT_W-1:0]              count_ext;

    assign period_sel = use_wait_reg ? wait_period : clock_period;
    assign count_ext  = EXT_W'(pixel_count_reg);

    // next state and result of one tick
    always_comb
    begin
        phase_next       = phase_reg;
        pixel_count_next = pixel_count_reg;
        tick_count_next  = tick_count_reg - 1'b1;
        use_wait_next    = use_wait_reg;
        si_next          = si_reg;
        clk_pin_next     = clk_pin_reg;
        result           = '0;

        if (tick_count_reg == '0)
        begin
            // reload from the period selected before this step; zero acts as one
            tick_count_next = (period_sel == '0) ? '0 : period_sel - 1'b1;
            unique case (phase_reg)
                PH_SET_SI:
                begin
                    si_next      = 1'b1;
                    clk_pin_next = 1'b0;
                    phase_next   = PH_SI_CLK;
                end
                PH_SI_CLK:
                begin
                    si_next      = 1'b1;
                    clk_pin_next = 1'b1;
                    phase_next   = PH_DROP_BOTH;
                end
                PH_DROP_BOTH:
                begin
                    si_next          = 1'b0;
                    clk_pin_next     = 1'b0;
                    result.adc_start = 1'b1;
                    phase_next       = PH_CAPTURE;
                end
                PH_CAPTURE:
                begin
                    if (adc_done)
                    begin
                        result.pixel_valid = 1'b1;
                        result.pixel_index = count_ext[lcrs_pkg::IDX_W-1:0];
                        result.pixel_value = adc_value;
                    end
                    else
                    begin
                        result.adc_miss = 1'b1;
                    end
                    si_next      = 1'b0;
                    clk_pin_next = 1'b1;
                    phase_next   = PH_DROP_CLK;
                end
                PH_DROP_CLK:
                begin
                    si_next      = 1'b0;
                    clk_pin_next = 1'b0;
                    if (pixel_count_reg == LAST_PIXEL)
                    begin
                        phase_next = PH_FRAME_END;
                    end
                    else
                    begin
                        result.adc_start = 1'b1;
                        pixel_count_next = pixel_count_reg + 1'b1;
                        phase_next       = PH_CAPTURE;
                    end
                end
                PH_FRAME_END:
                begin
                    si_next           = 1'b0;
                    clk_pin_next      = 1'b0;
                    result.frame_done = 1'b1;
                    use_wait_next     = 1'b1;
                    phase_next        = PH_INIT;
                end
                default:
                begin
                    // init, and the unused code
                    si_next          = 1'b0;
                    clk_pin_next     = 1'b0;
                    pixel_count_next = '0;
                    use_wait_next    = 1'b0;
                    phase_next       = PH_SET_SI;
                end
            endcase
        end

        result.si_level  = si_next;
        result.clk_level = clk_pin_next;
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_INIT;
            pixel_count_reg <= '0;
            tick_count_reg  <= '0;
            use_wait_reg    <= 1'b1;
            si_reg          <= 1'b0;
            clk_pin_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            pixel_count_reg <= pixel_count_next;
            tick_count_reg  <= tick_count_next;
            use_wait_reg    <= use_wait_next;
            si_reg          <= si_next;
            clk_pin_reg     <= clk_pin_next;
        end
    end

endmodule

>>> sv/lcrs_obuf.sv
// lcrs_obuf: output register with a skid stage for result beats
// depends on lcrs_pkg and lcrs_out_if

module lcrs_obuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lcrs_pkg::lcrs_result_t data,
    output logic                   space,
    lcrs_out_if.source             result
);

    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    lcrs_pkg::lcrs_result_t out_data_reg, out_data_next;
    lcrs_pkg::lcrs_result_t skid_data_reg, skid_data_next;
    logic                   take;

    assign take  = out_valid_reg && result.ready;
    assign space = !skid_valid_reg;

    // move beats between skid stage and output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = data;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.si_level    = out_data_reg.si_level;
    assign result.clk_level   = out_data_reg.clk_level;
    assign result.adc_start   = out_data_reg.adc_start;
    assign result.pixel_valid = out_data_reg.pixel_valid;
    assign result.pixel_index = out_data_reg.pixel_index;
    assign result.pixel_value = out_data_reg.pixel_value;
    assign result.frame_done  = out_data_reg.frame_done;
    assign result.adc_miss    = out_data_reg.adc_miss;

endmodule

>>> sv/line_camera_readout_sequencer.sv
// line_camera_readout_sequencer: linear sensor readout top level with period registers
// depends on lcrs_pkg, lcrs_in_if, lcrs_out_if, lcrs_seq, lcrs_obuf
// a result beat is offered in the cycle after its tick beat is taken,
// unless an earlier beat still waits in the output register; then it waits in the skid stage
// throughput: one tick beat per cycle; ready drops only while the skid stage holds a beat
// reset: clock period 250, wait period 500000, sequencer in init, timer expiring on first tick

module line_camera_readout_sequencer #(
    parameter int PIXEL_COUNT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcrs_pkg::DATA_W-1:0]   pwdata,
    output logic [lcrs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    lcrs_in_if.sink                       sample,
    lcrs_out_if.source                    result
);

    logic [lcrs_pkg::PERIOD_W-1:0] clock_period_reg;
    logic [lcrs_pkg::PERIOD_W-1:0] wait_period_reg;
    logic                          reg_write;
    logic                          reg_sel;
    logic                          space;
    logic                          accept;
    lcrs_pkg::lcrs_result_t        seq_res;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign reg_write = psel && penable && pwrite && pready;

    // period registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_period_reg <= lcrs_pkg::CLOCK_PERIOD_RST;
            wait_period_reg  <= lcrs_pkg::WAIT_PERIOD_RST;
        end
        else if (reg_write)
        begin
            if (reg_sel == lcrs_pkg::REG_CLOCK_PERIOD)
                clock_period_reg <= pwdata[lcrs_pkg::PERIOD_W-1:0];
            else
                wait_period_reg <= pwdata[lcrs_pkg::PERIOD_W-1:0];
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_sel)
            lcrs_pkg::REG_CLOCK_PERIOD: prdata = lcrs_pkg::DATA_W'(clock_period_reg);
            default:                    prdata = lcrs_pkg::DATA_W'(wait_period_reg);
        endcase
    end

    assign sample.ready = space;
    assign accept       = sample.valid && space;

    // sequencer
    lcrs_seq #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .adc_done     (sample.adc_done),
        .adc_value    (sample.adc_value),
        .clock_period (clock_period_reg),
        .wait_period  (wait_period_reg),
        .result       (seq_res)
    );

    // result buffering
    lcrs_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .data   (seq_res),
        .space  (space),
        .result (result)
    );

    // a taken tick always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> result.valid)
        else $error("result missing after accepted tick");

    // capture drives CLK high and SI low
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && seq_res.pixel_valid |-> seq_res.clk_level && !seq_res.si_level)
        else $error("pixel captured with wrong pin levels");

    // a conversion starts only with both pins low
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && seq_res.adc_start |-> !seq_res.clk_level && !seq_res.si_level)
        else $error("conversion started with a pin high");

endmodule

>>> tb/tb_line_camera_readout_sequencer.sv
// tb_line_camera_readout_sequencer: self-checking bench for the linear sensor readout sequencer
// depends on lcrs_pkg, lcrs_in_if, lcrs_out_if and line_camera_readout_sequencer
// drives tick beats and period writes, predicts every result beat and checks it in order

module tb_line_camera_readout_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXELS           = 128;
    localparam int IDLE_LIMIT       = 1000;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int PHASES           = 6;
    localparam logic [lcrs_pkg::PERIOD_W-1:0] PERIOD_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        SEQ_INIT, SEQ_RAISE_SI, SEQ_SI_CLK, SEQ_DROP_BOTH,
        SEQ_CAPTURE, SEQ_DROP_CLK, SEQ_FRAME_END
    } seq_phase_t;

    // expected result beats and the sequencer prediction behind them
    class readout_scoreboard;
        seq_phase_t                      phase;
        int                              pixel_pos;
        logic [lcrs_pkg::PERIOD_W-1:0]   ticks_left;
        logic [lcrs_pkg::PERIOD_W-1:0]   clock_per;
        logic [lcrs_pkg::PERIOD_W-1:0]   wait_per;
        bit                              use_wait;
        logic [1:0]                      pins;
        lcrs_pkg::lcrs_result_t          expected_beats[$];
        int                              errors;
        int                              ticks;
        int                              frames;
        int                              pixels;
        int                              misses;

        function new();
            phase      = SEQ_INIT;
            pixel_pos  = 0;
            ticks_left = '0;
            clock_per  = lcrs_pkg::CLOCK_PERIOD_RST;
            wait_per   = lcrs_pkg::WAIT_PERIOD_RST;
            use_wait   = 1'b1;
            pins       = 2'b00;
            errors     = 0;
            ticks      = 0;
            frames     = 0;
            pixels     = 0;
            misses     = 0;
        endfunction

        function void set_period(logic reg_sel, logic [lcrs_pkg::PERIOD_W-1:0] value);
            if (reg_sel == lcrs_pkg::REG_CLOCK_PERIOD)
                clock_per = value;
            else
                wait_per = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // one tick beat taken: advance timer and sequencer, queue the result
        function void note_tick(logic done, logic [lcrs_pkg::VALUE_W-1:0] value);
            lcrs_pkg::lcrs_result_t        beat;
            logic [lcrs_pkg::PERIOD_W-1:0] per;
            beat  = '0;
            ticks = ticks + 1;
            if (ticks_left == '0) begin
                per = use_wait ? wait_per : clock_per;
                // a zero period behaves as one
                if (per == '0)
                    per = 24'd1;
                ticks_left = per - 1'b1;
                case (phase)
                    SEQ_RAISE_SI: begin
                        pins  = 2'b01;
                        phase = SEQ_SI_CLK;
                    end
                    SEQ_SI_CLK: begin
                        pins  = 2'b11;
                        phase = SEQ_DROP_BOTH;
                    end
                    SEQ_DROP_BOTH: begin
                        pins           = 2'b00;
                        beat.adc_start = 1'b1;
                        phase          = SEQ_CAPTURE;
                    end
                    SEQ_CAPTURE: begin
                        if (done) begin
                            beat.pixel_valid = 1'b1;
                            beat.pixel_index = pixel_pos[lcrs_pkg::IDX_W-1:0];
                            beat.pixel_value = value;
                            pixels           = pixels + 1;
                        end
                        else begin
                            beat.adc_miss = 1'b1;
                            misses        = misses + 1;
                        end
                        pins  = 2'b10;
                        phase = SEQ_DROP_CLK;
                    end
                    SEQ_DROP_CLK: begin
                        pins = 2'b00;
                        if (pixel_pos >= PIXELS - 1)
                            phase = SEQ_FRAME_END;
                        else begin
                            beat.adc_start = 1'b1;
                            pixel_pos      = pixel_pos + 1;
                            phase          = SEQ_CAPTURE;
                        end
                    end
                    SEQ_FRAME_END: begin
                        pins            = 2'b00;
                        beat.frame_done = 1'b1;
                        use_wait        = 1'b1;
                        frames          = frames + 1;
                        phase           = SEQ_INIT;
                    end
                    default: begin
                        pins      = 2'b00;
                        pixel_pos = 0;
                        use_wait  = 1'b0;
                        phase     = SEQ_RAISE_SI;
                    end
                endcase
            end
            else begin
                ticks_left = ticks_left - 1'b1;
            end
            beat.si_level  = pins[0];
            beat.clk_level = pins[1];
            expected_beats.push_back(beat);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                errors = errors + 1;
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        // one result beat taken: compare with the oldest expectation
        function void check_result(lcrs_pkg::lcrs_result_t act);
            lcrs_pkg::lcrs_result_t exp_b;
            if (expected_beats.size() == 0) begin
                errors = errors + 1;
                $display("%0t: result beat with none expected, actual %h", $time, act);
                return;
            end
            exp_b = expected_beats.pop_front();
            compare_field("si_level", 8'(exp_b.si_level), 8'(act.si_level));
            compare_field("clk_level", 8'(exp_b.clk_level), 8'(act.clk_level));
            compare_field("adc_start", 8'(exp_b.adc_start), 8'(act.adc_start));
            compare_field("pixel_valid", 8'(exp_b.pixel_valid), 8'(act.pixel_valid));
            compare_field("pixel_index", 8'(exp_b.pixel_index), 8'(act.pixel_index));
            compare_field("pixel_value", exp_b.pixel_value, act.pixel_value);
            compare_field("frame_done", 8'(exp_b.frame_done), 8'(act.frame_done));
            compare_field("adc_miss", 8'(exp_b.adc_miss), 8'(act.adc_miss));
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lcrs_pkg::ADDR_W-1:0]   paddr;
    logic [lcrs_pkg::DATA_W-1:0]   pwdata;
    logic [lcrs_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    lcrs_in_if  sample_ch ();
    lcrs_out_if result_ch ();

    readout_scoreboard sb;
    int                beats_out   = 0;
    int                idle_cycles = 0;
    bit                sink_steady = 1'b0;

    logic [lcrs_pkg::VALUE_W-1:0]  corner_values [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                                         8'h01, 8'h80, 8'h7F, 8'hFE};
    logic [lcrs_pkg::PERIOD_W-1:0] clock_table [PHASES] =
        '{24'd1, 24'd2, 24'd0, 24'd1, 24'd1, 24'd3};
    logic [lcrs_pkg::PERIOD_W-1:0] wait_table [PHASES] =
        '{24'd1, 24'd5, 24'd0, 24'd40, 24'd9, 24'd2};
    int                            beats_table [PHASES] = '{220, 180, 200, 200, 150, 150};

    line_camera_readout_sequencer #(.PIXEL_COUNT(PIXELS)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch.sink),
        .result  (result_ch.source)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 24);
    endfunction

    // period register write: setup cycle then access cycle
    task automatic write_period(input logic reg_sel,
                                input logic [lcrs_pkg::PERIOD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {{(lcrs_pkg::DATA_W-lcrs_pkg::PERIOD_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_period(reg_sel, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // offer one tick beat, called and returning at a falling edge
    task automatic send_tick(input logic done, input logic [lcrs_pkg::VALUE_W-1:0] value,
                             input int gap);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.adc_done  <= done;
        sample_ch.adc_value <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering until every expected beat is back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // result side ready with random stalls and one long hold
    initial
    begin : sink_side
        int stall_left;
        bit long_hold_done;
        stall_left      = 0;
        long_hold_done  = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!long_hold_done && beats_out >= LONG_HOLD_AT) begin
                long_hold_done  = 1'b1;
                stall_left      = LONG_HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left      = stall_left - 1;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
                if (!sink_steady)
                    stall_left = pick_gap();
            end
        end
    end

    // beat monitor, checker and watchdog
    always @(posedge clk)
    begin
        lcrs_pkg::lcrs_result_t act;
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_tick(sample_ch.adc_done, sample_ch.adc_value);
            if (result_ch.valid && result_ch.ready) begin
                act.si_level    = result_ch.si_level;
                act.clk_level   = result_ch.clk_level;
                act.adc_start   = result_ch.adc_start;
                act.pixel_valid = result_ch.pixel_valid;
                act.pixel_index = result_ch.pixel_index;
                act.pixel_value = result_ch.pixel_value;
                act.frame_done  = result_ch.frame_done;
                act.adc_miss    = result_ch.adc_miss;
                sb.check_result(act);
                beats_out = beats_out + 1;
            end
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[line_camera_readout_sequencer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int  gap;
        bit  done;
        logic [lcrs_pkg::PERIOD_W-1:0] wait_value;
        sb                  = new();
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.adc_done  = 1'b0;
        sample_ch.adc_value = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero clock period acts as one, so every tick steps the sequencer
        write_period(lcrs_pkg::REG_CLOCK_PERIOD, 24'd0);
        write_period(lcrs_pkg::REG_WAIT_PERIOD, 24'd1);

        // directed: start of frame, corner samples, missed conversions
        for (int i = 0; i < 24; i++) begin
            done = !(i == 6 || i == 16 || i == 17);
            gap  = (i % 7 == 3) ? 2 : 0;
            send_tick(done, corner_values[i % 8], gap);
        end
        drain();

        // random phases over several period settings
        for (int p = 0; p < PHASES; p++) begin
            wait_value = (p == 4) ? 24'($urandom_range(1, 40)) : wait_table[p];
            write_period(lcrs_pkg::REG_CLOCK_PERIOD, clock_table[p]);
            write_period(lcrs_pkg::REG_WAIT_PERIOD, wait_value);
            sink_steady = (p == 2);
            for (int i = 0; i < beats_table[p]; i++) begin
                done = ($urandom_range(0, 9) != 0);
                gap  = (p == 0) ? 0 : pick_gap();
                send_tick(done, 8'($urandom_range(0, 255)), gap);
                // one pause mid-phase until all results are back
                if (p == 1 && i == beats_table[p] / 2)
                    drain();
            end
            drain();
        end
        sink_steady = 1'b0;

        // flush the timer with unit periods, then load the largest period
        write_period(lcrs_pkg::REG_CLOCK_PERIOD, 24'd1);
        write_period(lcrs_pkg::REG_WAIT_PERIOD, 24'd1);
        for (int i = 0; i < 60; i++)
            send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_gap());
        drain();
        write_period(lcrs_pkg::REG_CLOCK_PERIOD, PERIOD_MAX);
        write_period(lcrs_pkg::REG_WAIT_PERIOD, PERIOD_MAX);
        for (int i = 0; i < 30; i++)
            send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_gap());
        drain();
        repeat (5) @(negedge clk);

        $display("ticks checked %0d: %0d frames, %0d pixels captured, %0d missed conversions",
                 sb.ticks, sb.frames, sb.pixels, sb.misses);
        $display("periods from zero to full scale, output stalls and full drains included");
        if (sb.errors == 0)
            $display("[line_camera_readout_sequencer] OK");
        else
            $display("[line_camera_readout_sequencer] ERROR");
        $finish;
    end

endmodule

>>> line_camera_readout_sequencer.f
sv/lcrs_pkg.sv
sv/lcrs_in_if.sv
sv/lcrs_out_if.sv
sv/lcrs_seq.sv
sv/lcrs_obuf.sv
sv/line_camera_readout_sequencer.sv
tb/tb_line_camera_readout_sequencer.sv
